/* rtl/rgb_3x3_kernel_filter_top_defines.svh */
// assertion macros for the filter top rtl
`ifndef RGB_3X3_KERNEL_FILTER_TOP_DEFINES_SVH
`define RGB_3X3_KERNEL_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define RKF_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("rkf assertion failed");

`define RKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rkf assertion failed");

`else

`define RKF_ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`define RKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/rkf_pkg.sv */
package rkf_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        KM_BLUR     = 2'd0,
        KM_SHARPEN  = 2'd1,
        KM_EMBOSS   = 2'd2,
        KM_IDENTITY = 2'd3
    } t_kernel_mode;

    typedef logic [23:0] t_pix;

    // tap k = row*3 + column, row 0 is the oldest line, column 0 the oldest column
    typedef logic [8:0][23:0] t_taps;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [15:0] center_row;
        logic [9:0]  center_col;
        logic        frame_last;
    } t_out_beat;

endpackage

/* rtl/rkf_kernel.sv */
module rkf_kernel
    import rkf_pkg::*;
(
    input  t_kernel_mode i_mode,
    input  t_taps        i_taps,
    output t_pix         o_pix
);

    always_comb begin
        logic signed [12:0] v [9];
        logic signed [12:0] s;
        o_pix = '0;
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 9; k++) begin
                v[k] = $signed({5'b0, i_taps[k][8*ch +: 8]});
            end
            unique case (i_mode)
                KM_BLUR: begin
                    s = (v[0] >>> 4) + (v[2] >>> 4) + (v[6] >>> 4) + (v[8] >>> 4)
                      + (v[1] >>> 3) + (v[3] >>> 3) + (v[5] >>> 3) + (v[7] >>> 3)
                      + (v[4] >>> 2);
                end
                KM_SHARPEN: begin
                    s = 13'sd5 * v[4] - v[1] - v[3] - v[5] - v[7];
                end
                KM_EMBOSS: begin
                    s = v[4] + v[5] + v[7] + (v[8] <<< 1) - (v[0] <<< 1) - v[1] - v[3];
                end
                KM_IDENTITY: begin
                    s = v[4];
                end
                default: begin
                    s = v[4];
                end
            endcase
            if (s < 13'sd0) begin
                o_pix[8*ch +: 8] = 8'd0;
            end else if (s > 13'sd255) begin
                o_pix[8*ch +: 8] = 8'd255;
            end else begin
                o_pix[8*ch +: 8] = s[7:0];
            end
        end
    end

endmodule

/* rtl/rgb_3x3_kernel_filter_top.sv */
// channel   dir  handshake                 beat
// in        in   i_in_valid / o_in_ready   t_in_beat, one raster-order pixel
// out       out  o_out_valid / i_out_ready t_out_beat, one filtered interior pixel
// cfg       in   i_cfg_valid / o_cfg_ready index and data, always ready
//
// one pixel per cycle sustained unless a result stalls; a taken pixel goes to the kernel stage,
// then to the output register; the line memory read and the kernel stage load at the accepting edge
// a border pixel passes the kernel stage even while the output register is stalled
// an interior pixel waits in the kernel stage while the output is stalled
// synchronous active-low reset clears counters, window and valids, sets the config defaults; no clearing pass

`include "rgb_3x3_kernel_filter_top_defines.svh"

module rgb_3x3_kernel_filter_top
    import rkf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_kernel_mode     r_mode;
    logic [10:0]      r_width;
    logic [15:0]      r_height;
    logic [COL_W-1:0] r_col;
    logic [15:0]      r_row;
    logic [COL_W-1:0] n_col;
    logic [15:0]      n_row;

    logic [47:0]      r_line_mem [MAX_WIDTH];
    logic [47:0]      r_mem_q;

    logic             r_s1_valid;
    t_pix             r_s1_pix;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_emit;
    logic [15:0]      r_s1_crow;
    logic [9:0]       r_s1_ccol;
    logic             r_s1_last;

    t_pix             r_win [6];

    logic             r_out_valid;
    t_out_beat        r_out_data;

    logic [10:0]      w_eff;
    logic [15:0]      h_eff;
    logic [10:0]      col_inc;
    logic [16:0]      row_inc;
    logic             in_acc;
    logic             out_free;
    logic             s1_go;
    logic             emit;
    logic             last;
    t_pix             top_pix;
    t_pix             mid_pix;
    t_taps            taps;
    t_pix             filt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= KM_BLUR;
            r_width  <= 11'd512;
            r_height <= 16'd512;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KERNEL_MODE:  r_mode   <= t_kernel_mode'(i_cfg_data[1:0]);
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[10:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_width < 11'd3) begin
            w_eff = 11'd3;
        end else if (r_width > 11'(MAX_WIDTH)) begin
            w_eff = 11'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height < 16'd3) ? 16'd3 : r_height;
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_go      = r_s1_valid && (!r_s1_emit || out_free);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;

    assign col_inc = {1'b0, r_col} + 11'd1;
    assign row_inc = {1'b0, r_row} + 17'd1;
    assign emit    = (r_row >= 16'd2) && (r_col >= COL_W'(2));
    assign last    = (row_inc == {1'b0, h_eff}) && (col_inc == w_eff);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= {1'b0, h_eff}) ? 16'd0 : row_inc[15:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line memory: upper line in the high half, lower line in the low half
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem_q <= r_line_mem[r_col];
        end
        if (s1_go) begin
            r_line_mem[r_s1_col] <= {mid_pix, r_s1_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix  <= {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};
            r_s1_col  <= r_col;
            r_s1_emit <= emit;
            r_s1_crow <= r_row - 16'd1;
            r_s1_ccol <= 10'(r_col - COL_W'(1));
            r_s1_last <= last;
        end
    end

    assign top_pix = r_mem_q[47:24];
    assign mid_pix = r_mem_q[23:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (s1_go) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top_pix;
            r_win[4] <= mid_pix;
            r_win[5] <= r_s1_pix;
        end
    end

    always_comb begin
        taps[0] = r_win[0];
        taps[1] = r_win[3];
        taps[2] = top_pix;
        taps[3] = r_win[1];
        taps[4] = r_win[4];
        taps[5] = mid_pix;
        taps[6] = r_win[2];
        taps[7] = r_win[5];
        taps[8] = r_s1_pix;
    end

    rkf_kernel u_kernel (
        .i_mode (r_mode),
        .i_taps (taps),
        .o_pix  (filt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_emit) begin
            r_out_data.out_red    <= filt[23:16];
            r_out_data.out_green  <= filt[15:8];
            r_out_data.out_blue   <= filt[7:0];
            r_out_data.center_row <= r_s1_crow;
            r_out_data.center_col <= r_s1_ccol;
            r_out_data.frame_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a stalled interior pixel keeps its place in the kernel stage
    `RKF_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_go, r_s1_valid && $stable(r_s1_col))
    // read and write back never hit the same line entry in one cycle
    `RKF_ASSERT_ALWAYS(a_no_same_entry, i_clk, i_rst_n, !(in_acc && s1_go) || (r_col != r_s1_col))
    // a pixel is taken over a stalled result only when nothing would overwrite it
    `RKF_ASSERT_ALWAYS(a_no_overrun, i_clk, i_rst_n, !in_acc || out_free || !(r_s1_valid && r_s1_emit))

endmodule

/* tb/tb_rgb_3x3_kernel_filter_top.sv */
module tb_rgb_3x3_kernel_filter_top;
    import rkf_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 26;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_beat              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_beat             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always #5 clk = ~clk;

    rgb_3x3_kernel_filter_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // shadow copy of the filter state
    t_kernel_mode mode_q   = KM_BLUR;
    logic [10:0]  width_q  = 11'd512;
    logic [15:0]  height_q = 16'd512;
    t_pix         line_upper [MAX_WIDTH];
    t_pix         line_lower [MAX_WIDTH];
    t_pix         win_cols [6];
    int unsigned  col_q = 0;
    int unsigned  row_q = 0;

    t_out_beat    expected_pixels [$];
    t_out_beat    oldest;

    int unsigned  send_idle_pct   = IDLE_PCT;
    int unsigned  recv_idle_pct   = IDLE_PCT;
    bit           hold_request    = 1'b0;
    int unsigned  hold_left       = 0;
    int unsigned  cycles          = 0;
    int unsigned  error_count     = 0;
    int unsigned  pixels_sent     = 0;
    int unsigned  results_checked = 0;
    int unsigned  frame_ends_seen = 0;

    function automatic logic [7:0] kernel_channel(input t_kernel_mode m,
                                                  input logic [8:0][7:0] t);
        int v [9];
        int s;
        for (int k = 0; k < 9; k++) v[k] = int'(t[k]);
        case (m)
            KM_BLUR: begin
                s = (v[0] >> 4) + (v[2] >> 4) + (v[6] >> 4) + (v[8] >> 4)
                  + (v[1] >> 3) + (v[3] >> 3) + (v[5] >> 3) + (v[7] >> 3)
                  + (v[4] >> 2);
            end
            KM_SHARPEN: s = 5 * v[4] - v[1] - v[3] - v[5] - v[7];
            KM_EMBOSS:  s = -2 * v[0] - v[1] - v[3] + v[4] + v[5] + v[7] + 2 * v[8];
            default:    s = v[4];
        endcase
        if (s < 0) s = 0;
        else if (s > 255) s = 255;
        return s[7:0];
    endfunction

    task automatic convolve_pixel(input t_pix px);
        int unsigned     w;
        int unsigned     h;
        int unsigned     c;
        t_pix            top;
        t_pix            mid;
        t_pix            win [9];
        logic [8:0][7:0] taps;
        logic [7:0]      chan [3];
        t_out_beat       r;
        w = (width_q < 3) ? 3 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : width_q);
        h = (height_q < 3) ? 3 : height_q;
        c = col_q;
        top = line_upper[c];
        mid = line_lower[c];
        line_upper[c] = mid;
        line_lower[c] = px;
        win[0] = win_cols[0]; win[3] = win_cols[1]; win[6] = win_cols[2];
        win[1] = win_cols[3]; win[4] = win_cols[4]; win[7] = win_cols[5];
        win[2] = top;         win[5] = mid;         win[8] = px;
        if (row_q >= 2 && c >= 2) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int k = 0; k < 9; k++) taps[k] = win[k][23 - 8 * ch -: 8];
                chan[ch] = kernel_channel(mode_q, taps);
            end
            r.out_red    = chan[0];
            r.out_green  = chan[1];
            r.out_blue   = chan[2];
            r.center_row = 16'(row_q - 1);
            r.center_col = 10'(c - 1);
            r.frame_last = (row_q - 1 == h - 2) && (c - 1 == w - 2);
            expected_pixels.push_back(r);
        end
        win_cols[0] = win_cols[3];
        win_cols[1] = win_cols[4];
        win_cols[2] = win_cols[5];
        win_cols[3] = top;
        win_cols[4] = mid;
        win_cols[5] = px;
        if (c + 1 >= w) begin
            col_q = 0;
            row_q = (row_q + 1 >= h) ? 0 : ((row_q + 1) & 16'hFFFF);
        end else begin
            col_q = c + 1;
        end
    endtask

    function automatic logic [7:0] random_level();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_in_beat random_pixel();
        t_in_beat p;
        p.in_red   = random_level();
        p.in_green = random_level();
        p.in_blue  = random_level();
        return p;
    endfunction

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endtask

    task automatic send_pixel(input t_in_beat px);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        convolve_pixel(px);
        pixels_sent++;
    endtask

    // let every result drain, then give the pipeline time to empty of border pixels
    task automatic settle;
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input t_kernel_mode m, input logic [15:0] w,
                             input logic [15:0] h);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx[0] = CFG_KERNEL_MODE;  val[0] = '0; val[0][1:0] = m;
        idx[1] = CFG_IMAGE_WIDTH;  val[1] = w;
        idx[2] = CFG_IMAGE_HEIGHT; val[2] = h;
        settle();
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            case (idx[i])
                CFG_KERNEL_MODE:  mode_q = t_kernel_mode'(val[i][1:0]);
                CFG_IMAGE_WIDTH:  width_q = val[i][10:0];
                CFG_IMAGE_HEIGHT: height_q = val[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic finish_frame;
        while (col_q != 0 || row_q != 0) send_pixel(random_pixel());
    endtask

    task automatic test_directed;
        t_kernel_mode modes [3] = '{KM_BLUR, KM_SHARPEN, KM_EMBOSS};
        t_in_beat     p;
        for (int f = 0; f < 3; f++) begin
            configure(modes[f], 16'd3, 16'd3);
            for (int pos = 0; pos < 9; pos++) begin
                case (modes[f])
                    KM_BLUR:    p = '1;
                    KM_SHARPEN: p = (pos == 4) ? 24'hFF0080 : 24'h00FF01;
                    default: begin
                        p = (pos == 0) ? 24'h00FF10 :
                            (pos == 8) ? 24'hFF0020 : 24'h408000;
                    end
                endcase
                send_pixel(p);
            end
        end
    endtask

    // sizes below three act as three, width keeps only its low eleven bits
    task automatic test_config_extremes;
        t_kernel_mode  modes [3]   = '{KM_IDENTITY, KM_SHARPEN, KM_BLUR};
        logic [15:0]   widths [3]  = '{16'd0, 16'd2, 16'h0803};
        logic [15:0]   heights [3] = '{16'd1, 16'd0, 16'd2};
        for (int f = 0; f < 3; f++) begin
            configure(modes[f], widths[f], heights[f]);
            repeat (9) send_pixel(random_pixel());
        end
    endtask

    // an oversized width acts as a full line; the row of the next results shows the wrap
    task automatic test_wide_line;
        finish_frame();
        configure(t_kernel_mode'($urandom_range(3)), 16'hFFFF, 16'd4);
        repeat (MAX_WIDTH + 4) send_pixel(random_pixel());
        configure(mode_q, 16'd6, 16'd4);
        repeat (25) send_pixel(random_pixel());
    endtask

    task automatic test_geometry_change;
        // column already past the new width
        configure(mode_q, 16'd5, 16'd4);
        repeat (12) send_pixel(random_pixel());
        configure(t_kernel_mode'($urandom_range(3)), 16'd5, 16'hFFFF);
        repeat (60) send_pixel(random_pixel());
        // row already past the new height
        configure(mode_q, 16'd5, 16'd3);
        repeat (20) send_pixel(random_pixel());
    endtask

    task automatic test_output_stall;
        finish_frame();
        configure(t_kernel_mode'($urandom_range(3)), 16'd8, 16'd5);
        send_idle_pct = 0;
        hold_request  = 1'b1;
        repeat (120) send_pixel(random_pixel());
        send_idle_pct = IDLE_PCT;
    endtask

    task automatic test_random_frames;
        logic [15:0] w;
        logic [15:0] h;
        finish_frame();
        for (int f = 0; f < 12; f++) begin
            if (f == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (f == 8) begin
                send_idle_pct = IDLE_PCT;
                recv_idle_pct = IDLE_PCT;
            end
            w = ($urandom_range(4) == 0) ? 16'($urandom_range(40, 11))
                                          : 16'($urandom_range(10, 3));
            h = 16'($urandom_range(5, 3));
            configure(t_kernel_mode'($urandom_range(3)), w, h);
            repeat (w * h) send_pixel(random_pixel());
        end
    endtask

    always @(posedge clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_pixels.size() == 0) begin
                log_error($sformatf("unexpected beat row %0d col %0d rgb %02x %02x %02x",
                    out_data.center_row, out_data.center_col, out_data.out_red,
                    out_data.out_green, out_data.out_blue));
            end else begin
                oldest = expected_pixels.pop_front();
                results_checked++;
                if (out_data.out_red !== oldest.out_red
                        || out_data.out_green !== oldest.out_green
                        || out_data.out_blue !== oldest.out_blue
                        || out_data.center_row !== oldest.center_row
                        || out_data.center_col !== oldest.center_col
                        || out_data.frame_last !== oldest.frame_last) begin
                    log_error($sformatf(
                        "mismatch: expected row %0d col %0d rgb %02x %02x %02x last %0b",
                        oldest.center_row, oldest.center_col, oldest.out_red,
                        oldest.out_green, oldest.out_blue, oldest.frame_last));
                    if (error_count <= 10) begin
                        $display("          actual   row %0d col %0d rgb %02x %02x %02x last %0b",
                            out_data.center_row, out_data.center_col, out_data.out_red,
                            out_data.out_green, out_data.out_blue, out_data.frame_last);
                    end
                end else begin
                    frame_ends_seen += out_data.frame_last;
                end
            end
        end
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("rgb_3x3_kernel_filter_top test failed");
        $finish;
    end

    initial begin
        foreach (line_upper[i]) begin
            line_upper[i] = '0;
            line_lower[i] = '0;
        end
        foreach (win_cols[i]) win_cols[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_config_extremes();
        test_wide_line();
        test_geometry_change();
        test_output_stall();
        test_random_frames();
        settle();
        $display("%0d pixels in, %0d filtered beats checked, %0d frame ends, %0d errors",
            pixels_sent, results_checked, frame_ends_seen, error_count);
        $display("all four kernels, sizes from clamped minimum to full line and tallest frame,");
        $display("mid-frame geometry changes and a long output stall");
        if (error_count == 0) begin
            $display("rgb_3x3_kernel_filter_top test passed");
        end else begin
            $display("rgb_3x3_kernel_filter_top test failed");
        end
        $finish;
    end

endmodule
